/* hw/rtl/reno_cwc_pkg.sv */
`default_nettype none
package reno_cwc_pkg;

	localparam int WIN_W  = 24;
	localparam int ACK_FW = 16;
	localparam int DUP_W  = 3;
	localparam int CFG_IW = 2;

	localparam int FRAC_BITS_DEF = 8;
	localparam int SEQ_BITS_DEF  = 16;

	localparam logic [WIN_W-1:0] WIN_MAX      = {WIN_W{1'b1}};
	localparam logic [WIN_W-1:0] CWND_RST     = WIN_W'(256);
	localparam logic [WIN_W-1:0] SSTHRESH_RST = WIN_W'(10240);
	localparam logic [DUP_W-1:0] DUP_THR_RST  = DUP_W'(4);
	localparam logic [DUP_W-1:0] DUP_MAX      = DUP_W'(7);

	typedef enum logic [1:0] {
		MODE_ACK     = 2'd0,
		MODE_TIMEOUT = 2'd1,
		MODE_RESTART = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		PH_SLOW    = 2'd0,
		PH_AVOID   = 2'd1,
		PH_RECOVER = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		RETX_NONE    = 2'd0,
		RETX_FAST    = 2'd1,
		RETX_TIMEOUT = 2'd2
	} retx_t;

	typedef enum logic [CFG_IW-1:0] {
		CFG_INIT_WINDOW = 2'd0,
		CFG_INIT_THRESH = 2'd1,
		CFG_DUP_THRESH  = 2'd2
	} cfg_idx_t;

endpackage
`default_nettype wire

/* hw/rtl/reno_cwc_if.sv */
`default_nettype none
interface reno_cwc_evt_if import reno_cwc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic [ACK_FW-1:0] ack_number;

	modport source (output valid, output mode, output ack_number, input ready);
	modport sink (input valid, input mode, input ack_number, output ready);
endinterface

interface reno_cwc_rsp_if import reno_cwc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [WIN_W-1:0] window;
	logic [WIN_W-1:0] threshold;
	logic [1:0]       phase;
	logic [1:0]       retransmit;
	logic             was_duplicate;

	modport source (output valid, output window, output threshold, output phase,
		output retransmit, output was_duplicate, input ready);
	modport sink (input valid, input window, input threshold, input phase,
		input retransmit, input was_duplicate, output ready);
endinterface

interface reno_cwc_cfg_if import reno_cwc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [WIN_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/reno_congestion_window_control_top.sv */
// an accepted event goes from the idle state to the push state, which loads the output
// register; a new ack in avoidance first passes the divide and add states, the restoring
// divider giving one quotient bit a cycle; a new event is taken only back in the idle state
// a finished item waits in the output register while the next one is accepted
// reset (asynchronous): slow start, cwnd 256, ssthresh 10240, no remembered ack,
// registers back to 256, 10240 and 4; no clearing pass
`default_nettype none
module reno_congestion_window_control_top import reno_cwc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int SEQ_BITS  = SEQ_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	reno_cwc_cfg_if.sink   cfg,
	reno_cwc_evt_if.sink   evt,
	reno_cwc_rsp_if.source rsp
);

	localparam int QW    = 2 * FRAC_BITS + 1;
	localparam int CNT_W = $clog2(QW + 1);
	localparam int RW    = WIN_W + 1;
	localparam int SUM_W = ((QW > WIN_W) ? QW : WIN_W) + 1;
	localparam int ACK_W = (SEQ_BITS < ACK_FW) ? SEQ_BITS : ACK_FW;

	localparam logic [WIN_W-1:0] ONE_MSS   = WIN_W'(64'd1 << FRAC_BITS);
	localparam logic [WIN_W-1:0] THREE_MSS = WIN_W'(64'd3 << FRAC_BITS);
	localparam logic [QW-1:0]    NUM_INIT  = QW'(1) << (QW - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_ADD,
		S_PUSH
	} state_t;

	state_t           state_q;
	phase_t           phase_q;
	logic [WIN_W-1:0] cwnd_q;
	logic [WIN_W-1:0] ssthresh_q;
	logic [ACK_W-1:0] last_ack_q;
	logic             last_valid_q;
	logic [DUP_W-1:0] dup_cnt_q;
	logic [WIN_W-1:0] init_win_q;
	logic [WIN_W-1:0] init_thr_q;
	logic [DUP_W-1:0] dup_thr_q;
	retx_t            retx_q;
	logic             dup_q;

	// divider shift registers
	logic [RW-1:0]    rem_q;
	logic [QW-1:0]    num_q;
	logic [QW-1:0]    quot_q;
	logic [CNT_W-1:0] dcnt_q;

	logic             rsp_valid_q;
	logic [WIN_W-1:0] rsp_win_q;
	logic [WIN_W-1:0] rsp_thr_q;
	logic [1:0]       rsp_phase_q;
	logic [1:0]       rsp_retx_q;
	logic             rsp_dup_q;

	logic [ACK_W-1:0] ack_in;
	logic             is_dup;
	logic [DUP_W-1:0] cnt_inc;
	logic [WIN_W-1:0] half;
	logic [WIN_W-1:0] add_a;
	logic [SUM_W-1:0] add_b;
	logic [SUM_W-1:0] sum;
	logic [WIN_W-1:0] sat;
	logic [RW-1:0]    trial;
	logic             fits;
	logic [RW-1:0]    trial_sub;

	phase_t           n_phase;
	logic [WIN_W-1:0] n_cwnd;
	logic [WIN_W-1:0] n_ssthresh;
	logic [ACK_W-1:0] n_last_ack;
	logic             n_last_valid;
	logic [DUP_W-1:0] n_dup_cnt;
	retx_t            n_retx;
	logic             n_dup;
	logic             start_div;

	assign cfg.ready         = 1'b1;
	assign evt.ready         = (state_q == S_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.window        = rsp_win_q;
	assign rsp.threshold     = rsp_thr_q;
	assign rsp.phase         = rsp_phase_q;
	assign rsp.retransmit    = rsp_retx_q;
	assign rsp.was_duplicate = rsp_dup_q;

	// one divider step: shift in the next numerator bit, subtract when it fits
	assign trial     = {rem_q[RW-2:0], num_q[QW-1]};
	assign fits      = (trial >= {1'b0, cwnd_q});
	assign trial_sub = trial - {1'b0, cwnd_q};

	always_comb begin
		ack_in  = evt.ack_number[ACK_W-1:0];
		is_dup  = last_valid_q && (ack_in == last_ack_q);
		cnt_inc = (dup_cnt_q < DUP_MAX) ? DUP_W'(dup_cnt_q + DUP_W'(1)) : dup_cnt_q;
		half    = cwnd_q >> 1;

		// one shared saturating adder
		if (state_q == S_ADD) begin
			add_a = cwnd_q;
			add_b = SUM_W'(quot_q);
		end else if (is_dup && (phase_q != PH_RECOVER)) begin
			add_a = half;
			add_b = SUM_W'(THREE_MSS);
		end else begin
			add_a = cwnd_q;
			add_b = SUM_W'(ONE_MSS);
		end
		sum = SUM_W'(add_a) + add_b;
		sat = (sum > SUM_W'(WIN_MAX)) ? WIN_MAX : sum[WIN_W-1:0];

		n_phase      = phase_q;
		n_cwnd       = cwnd_q;
		n_ssthresh   = ssthresh_q;
		n_last_ack   = last_ack_q;
		n_last_valid = last_valid_q;
		n_dup_cnt    = dup_cnt_q;
		n_retx       = RETX_NONE;
		n_dup        = 1'b0;
		start_div    = 1'b0;

		unique case (evt.mode)
			MODE_ACK: begin
				if (is_dup) begin
					n_dup = 1'b1;
					if (phase_q == PH_RECOVER) begin
						n_cwnd = sat;
					end else begin
						n_dup_cnt = cnt_inc;
						if (cnt_inc >= dup_thr_q) begin
							n_ssthresh = half;
							n_cwnd     = sat;
							n_phase    = PH_RECOVER;
							n_retx     = RETX_FAST;
						end
					end
				end else begin
					n_last_ack   = ack_in;
					n_last_valid = 1'b1;
					n_dup_cnt    = DUP_W'(1);
					unique case (phase_q)
						PH_SLOW: begin
							n_cwnd = sat;
							if (sat >= ssthresh_q) begin
								n_phase = PH_AVOID;
							end
						end
						PH_AVOID: begin
							if (cwnd_q == '0) begin
								n_cwnd = WIN_MAX;
							end else begin
								start_div = 1'b1;
							end
						end
						PH_RECOVER: begin
							n_cwnd  = ssthresh_q;
							n_phase = PH_AVOID;
						end
						default: begin
							n_phase = phase_q;
						end
					endcase
				end
			end
			MODE_TIMEOUT: begin
				n_ssthresh   = half;
				n_cwnd       = ONE_MSS;
				n_phase      = PH_SLOW;
				n_last_valid = 1'b0;
				n_dup_cnt    = '0;
				n_retx       = RETX_TIMEOUT;
			end
			MODE_RESTART: begin
				n_cwnd       = init_win_q;
				n_ssthresh   = init_thr_q;
				n_phase      = PH_SLOW;
				n_last_ack   = '0;
				n_last_valid = 1'b0;
				n_dup_cnt    = '0;
			end
			default: begin
				n_retx = RETX_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= PH_SLOW;
			cwnd_q       <= CWND_RST;
			ssthresh_q   <= SSTHRESH_RST;
			last_ack_q   <= '0;
			last_valid_q <= 1'b0;
			dup_cnt_q    <= '0;
			init_win_q   <= CWND_RST;
			init_thr_q   <= SSTHRESH_RST;
			dup_thr_q    <= DUP_THR_RST;
			retx_q       <= RETX_NONE;
			dup_q        <= 1'b0;
			rem_q        <= '0;
			num_q        <= '0;
			quot_q       <= '0;
			dcnt_q       <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_win_q    <= '0;
			rsp_thr_q    <= '0;
			rsp_phase_q  <= '0;
			rsp_retx_q   <= '0;
			rsp_dup_q    <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					CFG_INIT_WINDOW: init_win_q <= cfg.data;
					CFG_INIT_THRESH: init_thr_q <= cfg.data;
					CFG_DUP_THRESH:  dup_thr_q  <= cfg.data[DUP_W-1:0];
					default: begin
						dup_thr_q <= dup_thr_q;
					end
				endcase
			end

			// the push state reloads the output register itself
			if (rsp_valid_q && rsp.ready && (state_q != S_PUSH)) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (evt.valid) begin
						phase_q      <= n_phase;
						cwnd_q       <= n_cwnd;
						ssthresh_q   <= n_ssthresh;
						last_ack_q   <= n_last_ack;
						last_valid_q <= n_last_valid;
						dup_cnt_q    <= n_dup_cnt;
						retx_q       <= n_retx;
						dup_q        <= n_dup;
						if (start_div) begin
							rem_q   <= '0;
							num_q   <= NUM_INIT;
							quot_q  <= '0;
							dcnt_q  <= CNT_W'(QW);
							state_q <= S_DIV;
						end else begin
							state_q <= S_PUSH;
						end
					end
				end
				S_DIV: begin
					rem_q  <= fits ? trial_sub : trial;
					num_q  <= num_q << 1;
					quot_q <= {quot_q[QW-2:0], fits};
					dcnt_q <= dcnt_q - CNT_W'(1);
					if (dcnt_q == CNT_W'(1)) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					cwnd_q  <= sat;
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_win_q   <= cwnd_q;
						rsp_thr_q   <= ssthresh_q;
						rsp_phase_q <= phase_q;
						rsp_retx_q  <= retx_q;
						rsp_dup_q   <= dup_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* tb/tb_reno_congestion_window_control_top.sv */
`default_nettype none
import reno_cwc_pkg::*;

localparam logic [WIN_W-1:0] ONE_MSS = WIN_W'(1) << FRAC_BITS_DEF;

typedef struct packed {
	logic [WIN_W-1:0] window;
	logic [WIN_W-1:0] threshold;
	phase_t           phase;
	retx_t            retx;
	logic             dup;
} cwnd_result_t;

class reno_scoreboard;
	logic [WIN_W-1:0]  init_window;
	logic [WIN_W-1:0]  init_thresh;
	logic [DUP_W-1:0]  dup_thresh;
	phase_t            cur_phase;
	logic [WIN_W-1:0]  cwnd;
	logic [WIN_W-1:0]  ssthresh;
	logic [ACK_FW-1:0] last_ack;
	logic              ack_seen;
	logic [DUP_W-1:0]  dup_cnt;
	cwnd_result_t      expected_q[$];
	int                errors;
	int                checked;
	int                fast_retx;
	int                saturated;

	function new();
		init_window = CWND_RST;
		init_thresh = SSTHRESH_RST;
		dup_thresh  = DUP_THR_RST;
		cur_phase   = PH_SLOW;
		cwnd        = CWND_RST;
		ssthresh    = SSTHRESH_RST;
		last_ack    = '0;
		ack_seen    = 1'b0;
		dup_cnt     = '0;
		errors      = 0;
		checked     = 0;
		fast_retx   = 0;
		saturated   = 0;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function void write_reg(cfg_idx_t idx, logic [WIN_W-1:0] d);
		case (idx)
			CFG_INIT_WINDOW: init_window = d;
			CFG_INIT_THRESH: init_thresh = d;
			CFG_DUP_THRESH:  dup_thresh = d[DUP_W-1:0];
			default: ;
		endcase
	endfunction

	// window increase, clamped at the top of the 24 bit range
	function logic [WIN_W-1:0] grow(logic [WIN_W-1:0] a, logic [WIN_W:0] b);
		logic [WIN_W+1:0] s;
		s = {2'b00, a} + {1'b0, b};
		return (s > {2'b00, WIN_MAX}) ? WIN_MAX : s[WIN_W-1:0];
	endfunction

	function void note_event(logic [1:0] m, logic [ACK_FW-1:0] a);
		cwnd_result_t r;
		int unsigned  incr;
		r.retx = RETX_NONE;
		r.dup  = 1'b0;
		case (m)
			MODE_ACK: begin
				if (ack_seen && a == last_ack) begin
					r.dup = 1'b1;
					if (cur_phase == PH_RECOVER) begin
						cwnd = grow(cwnd, {1'b0, ONE_MSS});
					end else begin
						if (dup_cnt < DUP_MAX)
							dup_cnt = dup_cnt + 1'b1;
						if (dup_cnt >= dup_thresh) begin
							ssthresh  = cwnd >> 1;
							cwnd      = grow(ssthresh, (WIN_W + 1)'(3 * ONE_MSS));
							cur_phase = PH_RECOVER;
							r.retx    = RETX_FAST;
						end
					end
				end else begin
					last_ack = a;
					ack_seen = 1'b1;
					dup_cnt  = DUP_W'(1);
					case (cur_phase)
						PH_SLOW: begin
							cwnd = grow(cwnd, {1'b0, ONE_MSS});
							if (cwnd >= ssthresh)
								cur_phase = PH_AVOID;
						end
						PH_AVOID: begin
							if (cwnd == '0) begin
								cwnd = WIN_MAX;
							end else begin
								incr = (32'd1 << (2 * FRAC_BITS_DEF)) / 32'(cwnd);
								cwnd = grow(cwnd, (WIN_W + 1)'(incr));
							end
						end
						default: begin
							cwnd      = ssthresh;
							cur_phase = PH_AVOID;
						end
					endcase
				end
			end
			MODE_TIMEOUT: begin
				ssthresh  = cwnd >> 1;
				cwnd      = ONE_MSS;
				cur_phase = PH_SLOW;
				ack_seen  = 1'b0;
				dup_cnt   = '0;
				r.retx    = RETX_TIMEOUT;
			end
			MODE_RESTART: begin
				cwnd      = init_window;
				ssthresh  = init_thresh;
				cur_phase = PH_SLOW;
				last_ack  = '0;
				ack_seen  = 1'b0;
				dup_cnt   = '0;
			end
			default: ;
		endcase
		r.window    = cwnd;
		r.threshold = ssthresh;
		r.phase     = cur_phase;
		expected_q  = {expected_q, r};
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task check_result(logic [WIN_W-1:0] w, logic [WIN_W-1:0] t, logic [1:0] ph,
		logic [1:0] rt, logic d);
		cwnd_result_t want;
		if (expected_q.size() == 0) begin
			report($sformatf("result window %h with nothing expected", w));
			return;
		end
		want = expected_q.pop_front();
		if (w !== want.window)
			report($sformatf("item %0d window %h, want %h", checked, w, want.window));
		if (t !== want.threshold)
			report($sformatf("item %0d threshold %h, want %h", checked, t, want.threshold));
		if (ph !== want.phase)
			report($sformatf("item %0d phase %0d, want %0d", checked, ph, want.phase));
		if (rt !== want.retx)
			report($sformatf("item %0d retransmit %0d, want %0d", checked, rt, want.retx));
		if (d !== want.dup)
			report($sformatf("item %0d was_duplicate %0d, want %0d", checked, d, want.dup));
		if (want.retx == RETX_FAST)
			fast_retx++;
		if (want.window == WIN_MAX)
			saturated++;
		checked++;
	endtask
endclass

module tb_reno_congestion_window_control_top;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int SETTLE      = 2 * FRAC_BITS_DEF + 4;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 3000;
	localparam int NUM_SETTINGS = 9;
	localparam int ITEMS_PER_SETTING = 190;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	reno_cwc_cfg_if cfg_if ();
	reno_cwc_evt_if evt_if ();
	reno_cwc_rsp_if rsp_if ();

	reno_congestion_window_control_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.evt(evt_if),
		.rsp(rsp_if)
	);

	reno_scoreboard    sb;
	logic [ACK_FW-1:0] cur_ack = '0;
	int                burst_left = 0;
	logic              hold_req = 1'b0;
	int                idle_cycles = 0;
	int                n_by_mode[4] = '{0, 0, 0, 0};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task send_event(input logic [1:0] m, input logic [ACK_FW-1:0] a);
		@(negedge clk);
		evt_if.valid      <= 1'b1;
		evt_if.mode       <= m;
		evt_if.ack_number <= a;
		do @(posedge clk); while (!evt_if.ready);
		sb.note_event(m, a);
		n_by_mode[m]++;
	endtask

	task sender_idle();
		@(negedge clk);
		evt_if.valid <= 1'b0;
	endtask

	// bursts of random length, random gaps between them
	task paced_event(input logic [1:0] m, input logic [ACK_FW-1:0] a);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				sender_idle();
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		send_event(m, a);
	endtask

	task write_reg(input cfg_idx_t idx, input logic [WIN_W-1:0] d);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= d;
		do @(posedge clk); while (!cfg_if.ready);
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task drain();
		sender_idle();
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task configure(input logic [WIN_W-1:0] iw, input logic [WIN_W-1:0] it,
		input logic [DUP_W-1:0] dt);
		int first;
		cfg_idx_t idx;
		drain();
		first = $urandom_range(0, 2);
		for (int k = 0; k < 3; k++) begin
			idx = cfg_idx_t'((first + k) % 3);
			case (idx)
				CFG_INIT_WINDOW: write_reg(idx, iw);
				CFG_INIT_THRESH: write_reg(idx, it);
				default:         write_reg(idx, WIN_W'(dt));
			endcase
		end
	endtask

	// mostly a plausible ack stream with duplicate runs, plus losses and noise
	task run_traffic(input int n);
		int k;
		int r;
		int run;
		int step;
		k = 0;
		while (k < n) begin
			r = $urandom_range(0, 99);
			if (r < 58) begin
				step = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535)
					: $urandom_range(1, 1460);
				cur_ack = cur_ack + ACK_FW'(step);
				paced_event(MODE_ACK, cur_ack);
				k++;
			end else if (r < 74) begin
				run = $urandom_range(1, 9);
				repeat (run) paced_event(MODE_ACK, cur_ack);
				k += run;
			end else if (r < 82) begin
				paced_event(MODE_TIMEOUT, ACK_FW'($urandom_range(0, 65535)));
				k++;
			end else if (r < 87) begin
				paced_event(MODE_RESTART, ACK_FW'($urandom_range(0, 65535)));
				k++;
			end else if (r < 93) begin
				paced_event(MODE_ACK, ACK_FW'($urandom_range(0, 65535)));
				k++;
			end else if (r < 96) begin
				paced_event(MODE_UNUSED, ACK_FW'($urandom_range(0, 65535)));
				k++;
			end else begin
				paced_event(MODE_ACK, ($urandom_range(0, 1) == 0) ? '0 : '1);
				k++;
			end
		end
	endtask

	// receiver: segments of steady, light and heavy stalling; long hold on request
	initial begin
		int seg;
		int style;
		rsp_if.ready = 1'b0;
		forever begin
			seg   = $urandom_range(10, 150);
			style = $urandom_range(0, 3);
			repeat (seg) begin
				@(negedge clk);
				if (hold_req) begin
					rsp_if.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
					hold_req = 1'b0;
				end
				case (style)
					0, 1:    rsp_if.ready <= 1'b1;
					2:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
					default: rsp_if.ready <= ($urandom_range(0, 2) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			sb.check_result(rsp_if.window, rsp_if.threshold, rsp_if.phase,
				rsp_if.retransmit, rsp_if.was_duplicate);
	end

	always @(posedge clk) begin
		if (!arst_n || (evt_if.valid && evt_if.ready) || (rsp_if.valid && rsp_if.ready)
			|| (cfg_if.valid && cfg_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("no progress for %0d cycles, %0d results outstanding",
					idle_cycles, sb.pending());
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [WIN_W-1:0] iw;
		logic [WIN_W-1:0] it;
		logic [DUP_W-1:0] dt;
		sb = new();
		evt_if.valid      = 1'b0;
		evt_if.mode       = MODE_ACK;
		evt_if.ack_number = '0;
		cfg_if.valid      = 1'b0;
		cfg_if.index      = CFG_INIT_WINDOW;
		cfg_if.data       = '0;
		arst_n            = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: duplicates into fast recovery, exit, avoidance, loss
		send_event(MODE_ACK, '0);
		repeat (3) send_event(MODE_ACK, '0);
		send_event(MODE_ACK, '0);
		send_event(MODE_ACK, '1);
		send_event(MODE_ACK, 16'h5555);
		send_event(MODE_ACK, 16'hAAAA);
		send_event(MODE_ACK, 16'hAAAA);
		send_event(MODE_UNUSED, '1);
		send_event(MODE_TIMEOUT, '0);
		// first ack after a loss is never a duplicate
		send_event(MODE_ACK, '1);
		send_event(MODE_ACK, '1);
		send_event(MODE_RESTART, 16'h1234);
		send_event(MODE_ACK, '0);
		send_event(MODE_ACK, '0);

		for (int p = 0; p < NUM_SETTINGS; p++) begin
			case (p)
				0: begin
					iw = WIN_W'(1);
					it = WIN_W'(1);
					dt = DUP_W'(2);
				end
				1: begin
					iw = WIN_MAX;
					it = WIN_MAX;
					dt = DUP_MAX;
				end
				2: begin
					iw = WIN_W'(512);
					it = WIN_W'(2048);
					dt = DUP_W'(1);
				end
				3: begin
					iw = WIN_W'($urandom_range(1, 24'hFFFFFF));
					it = WIN_W'($urandom_range(1, 24'hFFFFFF));
					dt = DUP_W'($urandom_range(2, 7));
				end
				4: begin
					iw = WIN_MAX - WIN_W'(300);
					it = WIN_MAX;
					dt = DUP_W'(3);
				end
				NUM_SETTINGS - 1: begin
					iw = CWND_RST;
					it = SSTHRESH_RST;
					dt = '0;
				end
				default: begin
					iw = WIN_W'($urandom_range(1, 4096));
					it = WIN_W'($urandom_range(256, 65536));
					dt = DUP_W'($urandom_range(2, 7));
				end
			endcase
			configure(iw, it, dt);
			send_event(MODE_RESTART, ACK_FW'($urandom_range(0, 65535)));
			cur_ack = cur_ack + 1'b1;
			send_event(MODE_ACK, cur_ack);
			if (p == 1) begin
				// output held off while new items keep coming
				hold_req = 1'b1;
				repeat (16) begin
					cur_ack = cur_ack + ACK_FW'($urandom_range(1, 1460));
					send_event(MODE_ACK, cur_ack);
				end
			end
			run_traffic(ITEMS_PER_SETTING);
		end

		drain();
		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending()));
		$display("events: %0d acks, %0d timeouts, %0d restarts, %0d unused mode, %0d settings",
			n_by_mode[MODE_ACK], n_by_mode[MODE_TIMEOUT], n_by_mode[MODE_RESTART],
			n_by_mode[MODE_UNUSED], NUM_SETTINGS + 1);
		$display("results checked %0d, fast retransmits %0d, saturated windows %0d, errors %0d",
			sb.checked, sb.fast_retx, sb.saturated, sb.errors);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire

/* reno_congestion_window_control_top.f */
hw/rtl/reno_cwc_pkg.sv
hw/rtl/reno_cwc_if.sv
hw/rtl/reno_congestion_window_control_top.sv
tb/tb_reno_congestion_window_control_top.sv
